// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the text layout core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define GQTL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define GQTL_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== hdl/gqtl_pkg.sv =====
// ----------------------------------------------------------------------------
// gqtl_pkg
// shared types, constants and arithmetic helpers of the text layout core
// ----------------------------------------------------------------------------
`default_nettype none

package gqtl_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int TBL_IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int ATLAS_LOG2    = 4;
  localparam int ATLAS_CELLS   = 1 << ATLAS_LOG2;
  localparam int CELL_W        = $clog2(ATLAS_CELLS + 1);
  localparam int EDGE_SH       = 16 - ATLAS_LOG2;
  localparam int POS_FRAC_BITS = 8;
  localparam int POS_UP        = (POS_FRAC_BITS >= 8) ? POS_FRAC_BITS - 8 : 0;
  localparam int POS_DN        = (POS_FRAC_BITS >= 8) ? 0 : 8 - POS_FRAC_BITS;

  localparam int TAB_SHIFT = 2;
  localparam int PROD_W    = 24 + TAB_SHIFT;
  localparam int INC_W     = PROD_W - 8;
  localparam int SAT_W     = INC_W + 1;
  localparam int SUM_W     = 48;
  localparam int TEX_W     = 19;
  localparam int TEX_OUT_W = 18;
  localparam int Q16_ONE   = 65536;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_VTAB    = 8'd11;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic [7:0]  GLYPH_SIZE_RST = 8'd16;
  localparam logic [15:0] RATIO_RST      = 16'd256;
  localparam logic [15:0] HALF_TEXEL_RST = 16'd128;
  localparam logic [15:0] MAX_GLYPHS_RST = 16'd256;

  localparam logic       KIND_VERTEX = 1'b0;
  localparam logic       KIND_EXTENT = 1'b1;
  localparam logic [1:0] CORNER_LAST = 2'd3;

  localparam logic signed [SUM_W-1:0] S32_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] S32_MIN = SUM_W'(-64'sd2147483648);

  typedef enum logic [1:0] {
    REQ_LOAD,
    REQ_CHAR,
    REQ_START,
    REQ_FINISH
  } req_e;

  typedef enum logic [1:0] {
    CFG_GLYPH_SIZE,
    CFG_RATIO,
    CFG_HALF_TEXEL,
    CFG_MAX_GLYPHS
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_START,
    OP_FINISH,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_VTAB,
    OP_SPACE,
    OP_GLYPH
  } op_e;

  typedef struct packed {
    logic [7:0]  glyph_size;
    logic [15:0] ratio_q8;
    logic [15:0] half_texel_q16;
    logic [15:0] max_glyphs;
  } cfg_t;

  typedef struct packed {
    req_e       req_type;
    logic [7:0] char_code;
    logic [7:0] advance_width;
    logic [7:0] line_height;
  } in_item_t;

  typedef struct packed {
    op_e               op;
    logic [7:0]        code;
    logic [PROD_W-1:0] prod;
  } q_entry_t;

  typedef struct packed {
    logic                        kind;
    logic [1:0]                  corner;
    logic [15:0]                 glyph_index;
    logic signed [31:0]          pos_x;
    logic signed [31:0]          pos_y;
    logic signed [TEX_OUT_W-1:0] tex_u;
    logic signed [TEX_OUT_W-1:0] tex_v;
    logic [15:0]                 extent_width;
    logic [15:0]                 extent_height;
    logic                        last;
  } out_item_t;

  // q8 product into position format
  function automatic logic signed [SUM_W-1:0] to_pos(input logic [PROD_W-1:0] q8);
    logic [SUM_W-1:0] t;
    t = SUM_W'(q8);
    t = (t << POS_UP) >> POS_DN;
    return signed'(t);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] sat16_add(input logic [15:0] a, input logic [INC_W-1:0] b);
    logic [SAT_W-1:0] s;
    s = SAT_W'(a) + SAT_W'(b);
    return (s > SAT_W'(16'hFFFF)) ? 16'hFFFF : s[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gqtl_fifo.sv =====
// ----------------------------------------------------------------------------
// gqtl_fifo
// short queue of classified operations between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gqtl_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gqtl_pkg::q_entry_t  entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output gqtl_pkg::q_entry_t  entry_o
);
  import gqtl_pkg::*;

  q_entry_t          store_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `GQTL_ASSERT_NEVER(a_fifo_overflow, clk_i, rst_ni, push_i && full_o)

endmodule

`default_nettype wire

// ===== hdl/gqtl_front.sv =====
// ----------------------------------------------------------------------------
// gqtl_front
// accepts requests, keeps the metric tables and classifies characters
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gqtl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gqtl_pkg::in_item_t  in_item_i,
  input  logic [15:0]         ratio_q8_i,
  output logic                q_push_o,
  output gqtl_pkg::q_entry_t  q_entry_o,
  input  logic                q_full_i
);
  import gqtl_pkg::*;

  logic [7:0]               adv_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] adv_vld_q;
  // only the newline entry of the height table is ever read
  logic [7:0]               sp_adv_q, nl_hgt_q;

  logic        s1_valid_q, s1_load_q;
  op_e         s1_op_q;
  logic [7:0]  s1_code_q, s1_alt_rast_q, s1_mem_q;
  logic        s1_alt_q, s1_mult4_q, s1_mem_vld_q;

  logic                 accept, s1_free, in_range, is_load;
  logic [TBL_IDX_W-1:0] idx;
  op_e                  op_d;
  logic                 alt_d, mult4_d;
  logic [7:0]           alt_rast_d, raster;
  logic [23:0]          prod24;
  logic [PROD_W-1:0]    prod;

  assign s1_free    = !s1_valid_q || s1_load_q || !q_full_i;
  assign in_ready_o = s1_free;
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = (in_item_i.req_type == REQ_LOAD);
  assign in_range   = ({1'b0, in_item_i.char_code} < 9'(TABLE_ENTRIES));
  assign idx        = in_item_i.char_code[TBL_IDX_W-1:0];

  always_comb begin
    op_d       = OP_GLYPH;
    alt_d      = 1'b0;
    mult4_d    = 1'b0;
    alt_rast_d = '0;
    case (in_item_i.req_type)
      REQ_START:  op_d = OP_START;
      REQ_FINISH: op_d = OP_FINISH;
      default: begin
        case (in_item_i.char_code)
          CH_NEWLINE: begin
            op_d       = OP_NEWLINE;
            alt_d      = 1'b1;
            alt_rast_d = nl_hgt_q;
          end
          CH_RETURN: op_d = OP_RETURN;
          CH_TAB: begin
            op_d       = OP_TAB;
            alt_d      = 1'b1;
            mult4_d    = 1'b1;
            alt_rast_d = sp_adv_q;
          end
          CH_VTAB: begin
            op_d       = OP_VTAB;
            alt_d      = 1'b1;
            mult4_d    = 1'b1;
            alt_rast_d = nl_hgt_q;
          end
          CH_SPACE: begin
            op_d       = OP_SPACE;
            alt_d      = 1'b1;
            alt_rast_d = sp_adv_q;
          end
          default: op_d = OP_GLYPH;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_load && in_range) begin
      adv_mem[idx] <= in_item_i.advance_width;
    end
    if (accept) begin
      s1_mem_q      <= adv_mem[idx];
      s1_mem_vld_q  <= adv_vld_q[idx] && in_range;
      s1_load_q     <= is_load;
      s1_op_q       <= op_d;
      s1_code_q     <= in_item_i.char_code;
      s1_alt_q      <= alt_d;
      s1_alt_rast_q <= alt_rast_d;
      s1_mult4_q    <= mult4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adv_vld_q  <= '0;
      sp_adv_q   <= '0;
      nl_hgt_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= accept;
      end
      if (accept && is_load && in_range) begin
        adv_vld_q[idx] <= 1'b1;
        if (in_item_i.char_code == CH_SPACE) begin
          sp_adv_q <= in_item_i.advance_width;
        end
        if (in_item_i.char_code == CH_NEWLINE) begin
          nl_hgt_q <= in_item_i.line_height;
        end
      end
    end
  end

  assign raster = s1_alt_q ? s1_alt_rast_q : (s1_mem_vld_q ? s1_mem_q : 8'd0);
  assign prod24 = {16'd0, raster} * {8'd0, ratio_q8_i};
  assign prod   = s1_mult4_q ? (PROD_W'(prod24) << TAB_SHIFT) : PROD_W'(prod24);

  assign q_push_o  = s1_valid_q && !s1_load_q && !q_full_i;
  assign q_entry_o = '{op: s1_op_q, code: s1_code_q, prod: prod};

  `GQTL_ASSERT(a_stalled_item_holds, clk_i, rst_ni,
    s1_valid_q && !s1_load_q && q_full_i |=> s1_valid_q && $stable(s1_code_q))

endmodule

`default_nettype wire

// ===== hdl/gqtl_back.sv =====
// ----------------------------------------------------------------------------
// gqtl_back
// executes queued operations: cursor, extent measurement and vertex output
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gqtl_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gqtl_pkg::cfg_t       cfg_i,
  input  logic                 q_valid_i,
  input  gqtl_pkg::q_entry_t   q_entry_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output gqtl_pkg::out_item_t  out_item_o
);
  import gqtl_pkg::*;

  logic signed [31:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [15:0]        quad_cnt_q, quad_cnt_d, line_w_q, line_w_d;
  logic [15:0]        widest_q, widest_d, text_h_q, text_h_d;
  logic [1:0]         corner_q, corner_d;
  logic               out_valid_q;
  out_item_t          out_q, out_d;

  logic                     out_free, emit, need_out, step, issue, last_corner;
  logic signed [SUM_W-1:0]  delta, gsz_pos;
  logic [INC_W-1:0]         inc;
  logic [15:0]              widest_max;
  logic [ATLAS_LOG2-1:0]    col, row;
  logic [TEX_W-1:0]         col_w, row_w, half_w, e_col, e_col1, e_row, e_row1, u, v;

  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = (q_entry_i.op == OP_GLYPH) && (quad_cnt_q < cfg_i.max_glyphs);
  assign need_out    = emit || (q_entry_i.op == OP_FINISH);
  assign step        = q_valid_i && (!need_out || out_free);
  assign issue       = step && need_out;
  assign last_corner = (corner_q == CORNER_LAST);
  assign q_pop_o     = step && (!emit || last_corner);

  assign delta      = to_pos(q_entry_i.prod);
  assign inc        = q_entry_i.prod[PROD_W-1:8];
  assign gsz_pos    = to_pos(PROD_W'({cfg_i.glyph_size, 8'h00}));
  assign widest_max = (line_w_q > widest_q) ? line_w_q : widest_q;

  // atlas cell edges
  assign col    = q_entry_i.code[ATLAS_LOG2-1:0];
  assign row    = q_entry_i.code[2*ATLAS_LOG2-1:ATLAS_LOG2];
  assign col_w  = TEX_W'(col);
  assign row_w  = TEX_W'(row);
  assign half_w = TEX_W'(cfg_i.half_texel_q16);
  assign e_col  = col_w << EDGE_SH;
  assign e_col1 = (col_w + 1'b1) << EDGE_SH;
  assign e_row  = row_w << EDGE_SH;
  assign e_row1 = (row_w + 1'b1) << EDGE_SH;
  assign u = corner_q[0] ? (e_col1 - half_w) : (e_col + half_w);
  assign v = corner_q[1] ? (TEX_W'(Q16_ONE) - e_row + half_w)
                         : (TEX_W'(Q16_ONE) - e_row1 - half_w);

  always_comb begin
    out_d = '0;
    if (emit) begin
      out_d.kind        = KIND_VERTEX;
      out_d.corner      = corner_q;
      out_d.glyph_index = quad_cnt_q;
      out_d.pos_x       = sat32(SUM_W'(cur_x_q) + (corner_q[0] ? gsz_pos : '0));
      out_d.pos_y       = sat32(SUM_W'(cur_y_q) + (corner_q[1] ? gsz_pos : '0));
      out_d.tex_u       = u[TEX_OUT_W-1:0];
      out_d.tex_v       = v[TEX_OUT_W-1:0];
      out_d.last        = last_corner;
    end else begin
      out_d.kind          = KIND_EXTENT;
      out_d.extent_width  = widest_max;
      out_d.extent_height = text_h_q;
      out_d.last          = 1'b1;
    end
  end

  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    quad_cnt_d = quad_cnt_q;
    line_w_d   = line_w_q;
    widest_d   = widest_q;
    text_h_d   = text_h_q;
    corner_d   = corner_q;
    if (step && emit) begin
      corner_d = last_corner ? '0 : corner_q + 1'b1;
    end
    if (q_pop_o) begin
      case (q_entry_i.op)
        OP_START: begin
          cur_x_d    = '0;
          cur_y_d    = '0;
          quad_cnt_d = '0;
          line_w_d   = '0;
          widest_d   = '0;
          text_h_d   = 16'(cfg_i.glyph_size);
        end
        OP_NEWLINE: begin
          widest_d = widest_max;
          line_w_d = '0;
          text_h_d = sat16_add(text_h_q, INC_W'(cfg_i.glyph_size));
          cur_x_d  = '0;
          cur_y_d  = sat32(SUM_W'(cur_y_q) - delta);
        end
        OP_RETURN: begin
          widest_d = widest_max;
          line_w_d = '0;
          cur_x_d  = '0;
        end
        OP_TAB, OP_SPACE: begin
          line_w_d = sat16_add(line_w_q, inc);
          cur_x_d  = sat32(SUM_W'(cur_x_q) + delta);
        end
        OP_VTAB: begin
          text_h_d = sat16_add(text_h_q, INC_W'({cfg_i.glyph_size, 2'b00}));
          cur_y_d  = sat32(SUM_W'(cur_y_q) - delta);
        end
        OP_GLYPH: begin
          line_w_d = sat16_add(line_w_q, inc);
          if (emit) begin
            cur_x_d    = sat32(SUM_W'(cur_x_q) + delta);
            quad_cnt_d = quad_cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      quad_cnt_q  <= '0;
      line_w_q    <= '0;
      widest_q    <= '0;
      text_h_q    <= 16'(GLYPH_SIZE_RST);
      corner_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      quad_cnt_q <= quad_cnt_d;
      line_w_q   <= line_w_d;
      widest_q   <= widest_d;
      text_h_q   <= text_h_d;
      corner_q   <= corner_d;
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `GQTL_ASSERT(a_corner_sequence, clk_i, rst_ni,
    out_valid_q && out_ready_i && out_q.kind == KIND_VERTEX && !out_q.last
    |=> out_valid_q && out_q.corner == $past(out_q.corner) + 2'd1)
  `GQTL_ASSERT(a_vertex_below_limit, clk_i, rst_ni,
    out_valid_q && out_q.kind == KIND_VERTEX |-> out_q.glyph_index < cfg_i.max_glyphs)

endmodule

`default_nettype wire

// ===== hdl/glyph_quad_text_layout_core.sv =====
// path: a character gives its first vertex through the input stage register, the
// queue and the output register, with the output free; a finish likewise its extent
// throughput: a printed character gives four vertices, one vertex per cycle through the
// output register while the sink is ready; load, start, control and skipped characters
// give no vertex; reset: cursor, counts, widths and table valid bits clear at once, text height and
// config return to defaults; no clearing pass, input is accepted right after reset
// ----------------------------------------------------------------------------
// glyph_quad_text_layout_core
// text layout against a square glyph atlas, emitting textured quad vertices
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_quad_text_layout_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // char_code, advance_width, line_height
  input  logic [1:0]   s_axis_tuser,  // req_type
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,  // corner, glyph_index, pos_x, pos_y, tex_u,
                                      // tex_v, extent_width, extent_height, zero pad
  output logic         m_axis_tuser,  // kind
  output logic         m_axis_tlast
);
  import gqtl_pkg::*;

  cfg_t      cfg_q;
  in_item_t  in_item;
  out_item_t out_item;
  q_entry_t  push_entry, head_entry;
  logic      push, full, head_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_size     <= GLYPH_SIZE_RST;
      cfg_q.ratio_q8       <= RATIO_RST;
      cfg_q.half_texel_q16 <= HALF_TEXEL_RST;
      cfg_q.max_glyphs     <= MAX_GLYPHS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GLYPH_SIZE: cfg_q.glyph_size     <= cfg_data_i[7:0];
        CFG_RATIO:      cfg_q.ratio_q8       <= cfg_data_i;
        CFG_HALF_TEXEL: cfg_q.half_texel_q16 <= cfg_data_i;
        CFG_MAX_GLYPHS: cfg_q.max_glyphs     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.req_type      = req_e'(s_axis_tuser);
  assign in_item.char_code     = s_axis_tdata[7:0];
  assign in_item.advance_width = s_axis_tdata[15:8];
  assign in_item.line_height   = s_axis_tdata[23:16];

  gqtl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .ratio_q8_i (cfg_q.ratio_q8),
    .q_push_o   (push),
    .q_entry_o  (push_entry),
    .q_full_i   (full)
  );

  gqtl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .entry_o (head_entry)
  );

  gqtl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (head_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = {2'b00, out_item.extent_height, out_item.extent_width,
                         out_item.tex_v, out_item.tex_u, out_item.pos_y, out_item.pos_x,
                         out_item.glyph_index, out_item.corner};
  assign m_axis_tuser = out_item.kind;
  assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire
